FILE: src/dfr_pkg.sv
package dfr_pkg;

   localparam logic [7:0]  START_BYTE    = 8'h02;
   localparam logic [7:0]  END_BYTE      = 8'h03;
   localparam logic [15:0] POLY_RESET    = 16'h1021;

   localparam logic [1:0]  STAT_GOOD     = 2'd0;
   localparam logic [1:0]  STAT_CRC_BAD  = 2'd1;
   localparam logic [1:0]  STAT_END_BAD  = 2'd2;

   typedef enum logic [2:0] {
      PH_WAIT    = 3'd0,
      PH_LEN     = 3'd1,
      PH_PAYLOAD = 3'd2,
      PH_CRC_HI  = 3'd3,
      PH_CRC_LO  = 3'd4,
      PH_END     = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      CMD_START   = 3'd0,
      CMD_PAYLOAD = 3'd1,
      CMD_CRC_HI  = 3'd2,
      CMD_CRC_LO  = 3'd3,
      CMD_END     = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic       is_status;
      logic [7:0] payload_byte;
      logic [1:0] frame_status;
      logic       frame_last;
   } rsp_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                              input logic [7:0]  data,
                                              input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: src/crc16_packet_deframer_unit.sv
// Deframer for start/length/payload/CRC-16/end frames on a byte stream.
// Input queue port: drive req_rx_byte with req_push; a byte is taken when
// req_full is low. Bytes outside a frame that are not a start byte vanish.
// Result queue port: while rsp_empty is low the oldest result is shown;
// raise rsp_pop to take it. Each payload byte yields one result; the end
// byte yields a status result with rsp_frame_last set.
// csr_wr_en/csr_wr_data load the CRC polynomial (reset 0x1021); write it
// only while no transaction is waiting in either queue.
// Throughput: one byte per cycle sustained while req_full stays low. A
// result passes from the command queue write through the CRC/status logic
// into the result queue before it is shown.
// When the receiver stalls, the result queue fills, the back stage holds,
// then the command queue fills and req_full rises; nothing is dropped.
// Reset (synchronous) empties both queues, returns the parser to waiting
// for a start byte and restores the default polynomial.
module crc16_packet_deframer_unit
   import dfr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_rx_byte,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_is_status,
   output logic [7:0]  rsp_payload_byte,
   output logic [1:0]  rsp_frame_status,
   output logic        rsp_frame_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   cmd_type cmd_wr, cmd_rd;
   rsp_type res_wr, res_rd;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic    res_push, res_full;

   dfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .cmd_push    (cmd_push),
      .cmd         (cmd_wr),
      .cmd_full    (cmd_full)
   );

   dfr_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   dfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd_rd),
      .cmd_empty   (cmd_empty),
      .cmd_pop     (cmd_pop),
      .rsp_push    (res_push),
      .rsp         (res_wr),
      .rsp_full    (res_full)
   );

   dfr_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_wr),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (res_rd),
      .empty   (rsp_empty)
   );

   assign rsp_is_status    = res_rd.is_status;
   assign rsp_payload_byte = res_rd.payload_byte;
   assign rsp_frame_status = res_rd.frame_status;
   assign rsp_frame_last   = res_rd.frame_last;

endmodule

FILE: src/dfr_queue.sv
module dfr_queue
   import dfr_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: src/dfr_front.sv
module dfr_front
   import dfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_rx_byte,
   output logic       req_full,
   output logic       cmd_push,
   output cmd_type    cmd,
   input  logic       cmd_full
);

   phase_type  phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] seen_ff, seen_in;
   logic [7:0] seen_next;
   logic       accept;

   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;
   assign seen_next = seen_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      seen_in   = seen_ff;
      cmd_push  = 1'b0;
      cmd.kind  = CMD_START;
      cmd.data  = req_rx_byte;
      if (accept) begin
         case (phase_ff)
            PH_LEN: begin
               length_in = req_rx_byte;
               seen_in   = '0;
               phase_in  = (req_rx_byte == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               cmd_push = 1'b1;
               cmd.kind = CMD_PAYLOAD;
               seen_in  = seen_next;
               if (seen_next == length_ff) begin
                  phase_in = PH_CRC_HI;
               end
            end
            PH_CRC_HI: begin
               cmd_push = 1'b1;
               cmd.kind = CMD_CRC_HI;
               phase_in = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               cmd_push = 1'b1;
               cmd.kind = CMD_CRC_LO;
               phase_in = PH_END;
            end
            PH_END: begin
               cmd_push = 1'b1;
               cmd.kind = CMD_END;
               phase_in = PH_WAIT;
            end
            default: begin
               phase_in = PH_WAIT;
               if (req_rx_byte == START_BYTE) begin
                  cmd_push = 1'b1;
                  cmd.kind = CMD_START;
                  phase_in = PH_LEN;
                  seen_in  = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         length_ff <= '0;
         seen_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

FILE: src/dfr_back.sv
module dfr_back
   import dfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  cmd_type     cmd,
   input  logic        cmd_empty,
   output logic        cmd_pop,
   output logic        rsp_push,
   output rsp_type     rsp,
   input  logic        rsp_full
);

   logic [15:0] poly_ff;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rcrc_ff, rcrc_in;
   logic        needs_slot;

   assign needs_slot = (cmd.kind inside {CMD_PAYLOAD, CMD_END});
   assign cmd_pop    = !cmd_empty && (!needs_slot || !rsp_full);

   always_comb begin
      crc_in           = crc_ff;
      rcrc_in          = rcrc_ff;
      rsp_push         = 1'b0;
      rsp.is_status    = 1'b0;
      rsp.payload_byte = cmd.data;
      rsp.frame_status = STAT_GOOD;
      rsp.frame_last   = 1'b0;
      if (cmd_pop) begin
         case (cmd.kind)
            CMD_START: begin
               crc_in  = '0;
               rcrc_in = '0;
            end
            CMD_PAYLOAD: begin
               crc_in   = crc_update(crc_ff, cmd.data, poly_ff);
               rsp_push = 1'b1;
            end
            CMD_CRC_HI: begin
               rcrc_in = {cmd.data, 8'h00};
            end
            CMD_CRC_LO: begin
               rcrc_in = {rcrc_ff[15:8], cmd.data};
            end
            CMD_END: begin
               rsp_push         = 1'b1;
               rsp.is_status    = 1'b1;
               rsp.payload_byte = '0;
               rsp.frame_last   = 1'b1;
               if (cmd.data != END_BYTE) begin
                  rsp.frame_status = STAT_END_BAD;
               end else if (crc_ff != rcrc_ff) begin
                  rsp.frame_status = STAT_CRC_BAD;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
         crc_ff  <= '0;
         rcrc_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            poly_ff <= csr_wr_data;
         end
         crc_ff  <= crc_in;
         rcrc_ff <= rcrc_in;
      end
   end

endmodule
